// ----- rtl/kst_pkg.sv -----
// Package for the keyed set table: field widths, command and status codes,
// and the packed entry type kept in the entry RAM. No dependencies.
package kst_pkg;

  // Default number of entries the table can hold.
  localparam int unsigned KST_CAPACITY = 16;

  // Widths of the item fields.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // Operation selected by an input item.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_GET    = 2'd3
  } kst_cmd_e;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // One stored entry: key in the upper half, handle in the lower half.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } kst_entry_t;

  localparam int unsigned ENTRY_W = KEY_W + HANDLE_W;

endpackage

// ----- rtl/kst_if.sv -----
// Handshake interfaces for the keyed set table: the request channel and the
// result channel, each with valid, ready and payload. Depends on kst_pkg.
interface kst_req_if import kst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [KEY_W-1:0] key;
  logic [HANDLE_W-1:0]     handle_in;

  modport source (output valid, cmd, key, handle_in, input ready);
  modport sink   (input valid, cmd, key, handle_in, output ready);
endinterface

interface kst_rsp_if import kst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    found;
  logic [HANDLE_W-1:0]     handle_out;
  logic signed [KEY_W-1:0] key_out;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, status, found, handle_out, key_out, count, input ready);
  modport sink   (input valid, status, found, handle_out, key_out, count, output ready);
endinterface

// ----- rtl/kst_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the keyed set table. No dependencies.
module kst_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/keyed_set_table.sv -----
// Keyed set table: up to Capacity key/handle entries packed in slots 0..count-1, one RAM.
// Add, get and remove search slots 0..count-1 in order until a match; remove then moves
// the last entry into the freed slot; pop reads the last entry, or returns ST_EMPTY when empty.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// handed to the output register, which the sink may leave waiting.
// Reset clears the entry count and the handshake state; the RAM is not cleared.
module keyed_set_table import kst_pkg::*; #(
  parameter int unsigned Capacity = KST_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kst_req_if.sink     req_i,
  kst_rsp_if.source   rsp_o
);

  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_MOVE_RD  = 3'd2;
  localparam logic [2:0] S_MOVE_WR  = 3'd3;
  localparam logic [2:0] S_POP_RD   = 3'd4;
  localparam logic [2:0] S_POP_DATA = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         idx_q, idx_d;
  logic [AddrW-1:0]        chk_q, chk_d;
  logic                    pend_q, pend_d;
  logic                    first_q, first_d;

  kst_cmd_e                cmd_q, cmd_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [HANDLE_W-1:0]     hin_q, hin_d;

  logic [STATUS_W-1:0]     res_status_q, res_status_d;
  logic                    res_found_q, res_found_d;
  logic [HANDLE_W-1:0]     res_handle_q, res_handle_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic                    out_found_q, out_found_d;
  logic [HANDLE_W-1:0]     out_handle_q, out_handle_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;

  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  kst_entry_t              ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]      ram_rdata_raw;
  logic [CntW-1:0]         last_idx;
  logic                    hit;
  logic                    req_fire, rsp_free;

  kst_ram #(
    .Width (ENTRY_W),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = kst_entry_t'(ram_rdata_raw);
  assign last_idx  = count_q - CntW'(1);
  assign hit       = pend_q && (ram_rdata.key == key_q);
  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_free  = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer: linear search, last-entry move and pop through the single RAM.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    chk_d        = chk_q;
    pend_d       = pend_q;
    first_d      = first_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    hin_d        = hin_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_handle_d = res_handle_q;
    res_key_d    = res_key_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = chk_q;
    ram_raddr    = last_idx[AddrW-1:0];
    ram_wdata    = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_d        = kst_cmd_e'(req_i.cmd);
          key_d        = req_i.key;
          hin_d        = req_i.handle_in;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_handle_d = '0;
          res_key_d    = req_i.key;
          idx_d        = '0;
          pend_d       = 1'b0;
          first_d      = 1'b1;
          if (kst_cmd_e'(req_i.cmd) == CMD_POP) begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              state_d = S_POP_RD;
            end
          end else begin
            state_d = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          // The entry read last cycle matches the key.
          res_found_d  = 1'b1;
          res_handle_d = ram_rdata.handle;
          chk_d        = chk_q;
          case (cmd_q)
            CMD_ADD: begin
              res_status_d = ST_PRESENT;
              state_d      = S_RESP;
            end
            CMD_REMOVE: begin
              state_d = S_MOVE_RD;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end else if (pend_q || first_q) begin
          // Issue the read of the next occupied slot, if any remain.
          first_d = 1'b0;
          if (idx_q < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q[AddrW-1:0];
            chk_d     = idx_q[AddrW-1:0];
            idx_d     = idx_q + CntW'(1);
            pend_d    = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end else begin
          // Every occupied slot was checked without a match.
          if (cmd_q == CMD_ADD) begin
            if (count_q == CntW'(Capacity)) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AddrW-1:0];
              ram_wdata = '{key: key_q, handle: hin_q};
              count_d   = count_q + CntW'(1);
            end
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
          state_d = S_RESP;
        end
      end

      S_MOVE_RD: begin
        ram_re  = 1'b1;
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        // Move the last entry into the freed slot.
        ram_we    = 1'b1;
        ram_waddr = chk_q;
        ram_wdata = ram_rdata;
        count_d   = last_idx;
        state_d   = S_RESP;
      end

      S_POP_RD: begin
        ram_re  = 1'b1;
        state_d = S_POP_DATA;
      end

      S_POP_DATA: begin
        res_key_d    = ram_rdata.key;
        res_handle_d = ram_rdata.handle;
        count_d      = last_idx;
        state_d      = S_RESP;
      end

      S_RESP: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the finished result when the slot is free.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_handle_d = out_handle_q;
    out_key_d    = out_key_q;
    out_count_d  = out_count_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_RESP) && rsp_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_found_d  = res_found_q;
      out_handle_d = res_handle_q;
      out_key_d    = res_key_q;
      out_count_d  = COUNT_W'(count_q);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    chk_q        <= chk_d;
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    hin_q        <= hin_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_handle_q <= res_handle_d;
    res_key_q    <= res_key_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_handle_q <= out_handle_d;
    out_key_q    <= out_key_d;
    out_count_q  <= out_count_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.handle_out = out_handle_q;
  assign rsp_o.key_out    = out_key_q;
  assign rsp_o.count      = out_count_q;

  // The table never holds more entries than its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  // The RAM is written only when appending an entry or moving the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SEARCH) || (state_q == S_MOVE_WR))
    else $error("RAM write outside append or move");

  // A new result appears only when the sequencer finishes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result raised without a finished item");

  // The count changes by at most one per item and only while working on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_RESP) |=> $stable(count_q))
    else $error("entry count changed outside an item");

  // An accepted item leaves the idle state on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after taking an item");

endmodule
